@@ src/csvrfs_pkg.sv @@
// ----------------------------------------------------------------------------
// CSV row splitter package
// Shared widths, result codes, character constants and the result record.
// ----------------------------------------------------------------------------
package csvrfs_pkg;

   localparam int MAX_FIELD_BUFFER = 4096;
   localparam int MAX_COLUMNS      = 8;

   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int COL_W    = 4;
   localparam int ERR_W    = 2;
   localparam int CNT_W    = 12;
   localparam int FBS_W    = 13;
   localparam int CSR_IDX_W = 1;
   localparam int RSP_DATA_W = 16;

   localparam logic [KIND_W-1:0] KIND_CHAR      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIELD_END = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ROW_DONE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd3;

   localparam logic [ERR_W-1:0] ERR_COLUMNS = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LENGTH  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_QUOTE   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_COLUMN_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FIELD_BUFFER = 1'd1;

   localparam logic [COL_W-1:0] COLUMN_LIMIT_RESET = 4'd4;
   localparam logic [FBS_W-1:0] FIELD_BUFFER_RESET = 13'd256;

   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

   typedef struct packed {
      logic [ERR_W-1:0]  error_code;
      logic [COL_W-1:0]  column;
      logic [BYTE_W-1:0] char_out;
      logic [KIND_W-1:0] kind;
   } result_type;

endpackage

@@ src/csv_row_field_splitter_top.sv @@
// ----------------------------------------------------------------------------
// CSV row field splitter
// A result is registered in the output register, or in the skid entry if stalled.
// Throughput: one request per cycle while the skid entry is empty; the state
// update is a single pass of compares and one 13-bit add/compare on the field
// character count. A two-entry output stage (result register plus skid) keeps
// req_tready registered. Synchronous active-high reset clears row state and the
// output stage, and loads column_limit = 4 and field_buffer_size = 256.
// ----------------------------------------------------------------------------
module csv_row_field_splitter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [csvrfs_pkg::BYTE_W-1:0]     req_tdata,   // [7:0] text_byte
   input  logic                              req_tlast,   // row_end
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] char_out, [11:8] column, [13:12] error_code, [15:14] zero
   output logic [csvrfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [csvrfs_pkg::KIND_W-1:0]     rsp_tuser,   // [1:0] kind
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [csvrfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [csvrfs_pkg::FBS_W-1:0]      csr_data
);
   import csvrfs_pkg::*;

   // configuration
   logic [COL_W-1:0] col_limit_ff;
   logic [FBS_W-1:0] buf_size_ff;
   logic [COL_W-1:0] eff_cols;
   logic [FBS_W-1:0] eff_buf;

   // row state
   logic             quoted_ff, quoted_in;
   logic             pending_ff, pending_in;
   logic [COL_W-1:0] field_ff, field_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             discard_ff, discard_in;

   // output stage
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;

   logic       req_fire;
   logic       res_valid;
   result_type res;

   // datapath temporaries
   logic [BYTE_W-1:0] b;
   logic              q_eff;
   logic              is_term;
   logic              col_full;
   logic              do_append;
   logic [BYTE_W-1:0] app_ch;
   logic [FBS_W-1:0]  count_next;

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   assign eff_cols = (col_limit_ff > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : col_limit_ff;
   assign eff_buf  = (buf_size_ff > FBS_W'(MAX_FIELD_BUFFER)) ?
                     FBS_W'(MAX_FIELD_BUFFER) : buf_size_ff;

   assign b          = req_tdata;
   assign col_full   = (field_ff >= eff_cols);
   assign is_term    = (b == CH_NUL) || (b == CH_LF) || (b == CH_CR);
   assign count_next = {1'b0, count_ff} + FBS_W'(1);

   always_comb begin
      quoted_in  = quoted_ff;
      pending_in = pending_ff;
      field_in   = field_ff;
      count_in   = count_ff;
      discard_in = discard_ff;
      res_valid  = 1'b0;
      res        = '0;
      q_eff      = quoted_ff;
      do_append  = 1'b0;
      app_ch     = b;

      if (req_tlast) begin
         if (!discard_ff) begin
            res_valid = 1'b1;
            if (quoted_ff && !pending_ff) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_QUOTE;
            end else if (col_full) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_COLUMNS;
            end else begin
               res.kind   = KIND_ROW_DONE;
               res.column = field_ff + COL_W'(1);
            end
         end
         quoted_in  = 1'b0;
         pending_in = 1'b0;
         field_in   = '0;
         count_in   = '0;
         discard_in = 1'b0;
      end else if (!discard_ff) begin
         if (pending_ff) begin
            pending_in = 1'b0;
            q_eff      = 1'b0;
         end
         if (pending_ff && b == CH_QUOTE) begin
            // doubled quote: literal quote, quoting stays open
            do_append = 1'b1;
            app_ch    = CH_QUOTE;
         end else if (b == CH_QUOTE) begin
            quoted_in = 1'b1;
            if (q_eff) begin
               pending_in = 1'b1;
            end
         end else begin
            quoted_in = q_eff;
            if (q_eff && b == CH_NUL) begin
               res_valid      = 1'b1;
               res.kind       = KIND_ERROR;
               res.error_code = ERR_QUOTE;
               discard_in     = 1'b1;
            end else if (!q_eff && (b == CH_COMMA || is_term)) begin
               res_valid = 1'b1;
               if (col_full) begin
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_COLUMNS;
                  discard_in     = 1'b1;
               end else if (b == CH_COMMA) begin
                  res.kind   = KIND_FIELD_END;
                  res.column = field_ff;
                  field_in   = field_ff + COL_W'(1);
                  count_in   = '0;
               end else begin
                  res.kind   = KIND_ROW_DONE;
                  res.column = field_ff + COL_W'(1);
                  discard_in = 1'b1;
               end
            end else begin
               do_append = 1'b1;
            end
         end

         if (do_append) begin
            res_valid = 1'b1;
            if (col_full) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_COLUMNS;
               discard_in     = 1'b1;
            end else if (count_next >= eff_buf) begin
               res.kind       = KIND_ERROR;
               res.error_code = ERR_LENGTH;
               discard_in     = 1'b1;
            end else begin
               res.kind     = KIND_CHAR;
               res.char_out = app_ch;
               res.column   = field_ff;
               count_in     = count_next[CNT_W-1:0];
            end
         end
      end
   end

   // output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (req_fire && res_valid) begin
         if (!out_valid_ff || rsp_tready) begin
            out_valid_in = 1'b1;
            out_data_in  = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_limit_ff  <= COLUMN_LIMIT_RESET;
         buf_size_ff   <= FIELD_BUFFER_RESET;
         quoted_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         field_ff      <= '0;
         count_ff      <= '0;
         discard_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_COLUMN_LIMIT: col_limit_ff <= csr_data[COL_W-1:0];
               REG_FIELD_BUFFER: buf_size_ff  <= csr_data;
               default: ;
            endcase
         end
         if (req_fire) begin
            quoted_ff  <= quoted_in;
            pending_ff <= pending_in;
            field_ff   <= field_in;
            count_ff   <= count_in;
            discard_ff <= discard_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_data_ff.kind;
   assign rsp_tdata  = {2'b00, out_data_ff.error_code, out_data_ff.column,
                        out_data_ff.char_out};

endmodule

@@ src/csvrfs_checker.sv @@
// ----------------------------------------------------------------------------
// CSV row splitter checker
// Port-level checks on the result stream and req_tready, bound to the top level.
// ----------------------------------------------------------------------------
module csvrfs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [csvrfs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [csvrfs_pkg::KIND_W-1:0]     rsp_tuser
);
   import csvrfs_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output stage not cleared by reset");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |-> rsp_tdata[11:0] == 12'd0 &&
      rsp_tdata[13:12] != 2'd3)
      else $error("error result carries stray fields");

   a_row_done_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ROW_DONE |-> rsp_tdata[11:8] != 4'd0 &&
      rsp_tdata[7:0] == 8'd0 && rsp_tdata[13:12] == 2'd0)
      else $error("row complete without field count");

   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with empty output");

endmodule

bind csv_row_field_splitter_top csvrfs_checker u_csvrfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
